FILE: src/sood_pkg.sv
// Package for the segment onset/offset detector: widths, register indexes,
// state machine type and controller/datapath command and status structs. No dependencies.
`default_nettype none
package sood_pkg;
   localparam int SampleBits = 16;
   localparam int MaxSegLen  = 65536;
   localparam int IdxBits    = 17;
   localparam int PosBits    = 16;
   localparam int TimeBits   = 36;
   localparam int DivBits    = 64;

   localparam logic [2:0] RegOnsetThr  = 3'd0;
   localparam logic [2:0] RegOffsetThr = 3'd1;
   localparam logic [2:0] RegUseMag    = 3'd2;
   localparam logic [2:0] RegTimeMode  = 3'd3;
   localparam logic [2:0] RegPeriod    = 3'd4;

   localparam logic [1:0] ModeFrac  = 2'd0;
   localparam logic [1:0] ModeUs    = 2'd1;
   localparam logic [1:0] ModeFrame = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIV_ON, ST_DIV_OFF, ST_DIV_RATE, ST_OUT
   } state_type;

   typedef struct packed {
      logic take;      // accept sample
      logic start_mul; // register products
      logic div_start;
      logic [1:0] div_sel; // 0 onset, 1 offset, 2 rate
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic seg_end;  // accepted sample was last
      logic div_busy;
      logic frac_mode;
   } stat_type;

   localparam logic [1:0] SelOn   = 2'd0;
   localparam logic [1:0] SelOff  = 2'd1;
   localparam logic [1:0] SelRate = 2'd2;
endpackage
`default_nettype wire

FILE: src/sood_if.sv
// Valid/ready channel interfaces for request and response.
// Depends on sood_pkg.
`default_nettype none
interface sood_req_if;
   logic valid;
   logic ready;
   logic signed [sood_pkg::SampleBits-1:0] sample;
   logic last_sample;
   modport source (output valid, sample, last_sample, input ready);
   modport sink (input valid, sample, last_sample, output ready);
endinterface

interface sood_rsp_if;
   logic valid;
   logic ready;
   logic [35:0] onset_time;
   logic [35:0] offset_time;
   logic [15:0] onset_count;
   logic [15:0] offset_count;
   logic [23:0] onset_rate;
   logic [16:0] segment_length;
   logic overflow;
   modport source (output valid, onset_time, offset_time, onset_count, offset_count,
                   onset_rate, segment_length, overflow, input ready);
   modport sink (input valid, onset_time, offset_time, onset_count, offset_count,
                 onset_rate, segment_length, overflow, output ready);
endinterface
`default_nettype wire

FILE: src/sood_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, 64-bit operands.
// Depends on sood_pkg.
`default_nettype none
module sood_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [sood_pkg::DivBits-1:0] dividend,
   input  wire logic [sood_pkg::DivBits-1:0] divisor,
   output logic busy,
   output logic [sood_pkg::DivBits-1:0] quotient
);
   localparam int N = sood_pkg::DivBits;
   logic [N-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [N:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[N-1]} - {1'b0, den_ff};
      if (start) begin
         quo_in = dividend; rem_in = '0; den_in = divisor; cnt_in = 7'(N);
      end else if (cnt_ff != 7'd0) begin
         if (!trial[N]) begin
            rem_in = trial[N-1:0];
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[N-2:0], quo_ff[N-1]};
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign busy = (cnt_ff != 7'd0);
   assign quotient = quo_ff;
endmodule
`default_nettype wire

FILE: src/sood_datapath.sv
// Datapath: config registers, per-sample hysteresis tracking, end-of-segment
// formatting with a shared divider. Depends on sood_pkg, sood_div.
`default_nettype none
module sood_datapath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write_enable,
   input  wire logic [2:0] csr_index,
   input  wire logic [19:0] csr_write_data,
   input  wire logic signed [sood_pkg::SampleBits-1:0] sample,
   input  wire logic last_sample,
   input  wire sood_pkg::cmd_type cmd,
   output sood_pkg::stat_type stat,
   output logic [35:0] onset_time,
   output logic [35:0] offset_time,
   output logic [15:0] onset_count,
   output logic [15:0] offset_count,
   output logic [23:0] onset_rate,
   output logic [16:0] segment_length,
   output logic overflow
);
   localparam int SB = sood_pkg::SampleBits;
   localparam logic [16:0] MaxLen = 17'(sood_pkg::MaxSegLen);
   localparam logic [63:0] Mask36 = 64'h0000_000F_FFFF_FFFF;

   logic signed [15:0] on_thr_ff, off_thr_ff;
   logic use_mag_ff;
   logic [1:0] mode_ff;
   logic [19:0] per_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_thr_ff <= '0; off_thr_ff <= '0; use_mag_ff <= 1'b0;
         mode_ff <= sood_pkg::ModeFrac; per_ff <= 20'd10000;
      end else if (csr_write_enable) begin
         case (csr_index)
            sood_pkg::RegOnsetThr:  on_thr_ff <= csr_write_data[15:0];
            sood_pkg::RegOffsetThr: off_thr_ff <= csr_write_data[15:0];
            sood_pkg::RegUseMag:    use_mag_ff <= csr_write_data[0];
            sood_pkg::RegTimeMode:  mode_ff <= csr_write_data[1:0];
            sood_pkg::RegPeriod:    per_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // segment tracking state
   logic above_ff, above_in, on_seen_ff, on_seen_in, off_seen_ff, off_seen_in;
   logic ovf_ff, ovf_in;
   logic [16:0] idx_ff, idx_in;
   logic [15:0] first_on_ff, first_on_in, last_off_ff, last_off_in;
   logic [15:0] on_cnt_ff, on_cnt_in, off_cnt_ff, off_cnt_in;
   logic signed [SB:0] cur;
   logic [15:0] pos;
   logic gt_on, le_off, ab;
   logic end_ff;

   // captured end-of-segment snapshot
   logic [16:0] len_ff;
   logic [15:0] son_ff, soff_ff, son_cnt_ff, soff_cnt_ff;
   logic sovf_ff;

   always_comb begin
      cur = (use_mag_ff && sample[SB-1]) ? -{sample[SB-1], sample} : {sample[SB-1], sample};
      gt_on = cur > $signed({on_thr_ff[15], on_thr_ff});
      le_off = cur <= $signed({off_thr_ff[15], off_thr_ff});
      above_in = above_ff; idx_in = idx_ff; on_seen_in = on_seen_ff; off_seen_in = off_seen_ff;
      ovf_in = ovf_ff; first_on_in = first_on_ff; last_off_in = last_off_ff;
      on_cnt_in = on_cnt_ff; off_cnt_in = off_cnt_ff;
      if (idx_ff < MaxLen) begin
         pos = idx_ff[15:0];
         idx_in = idx_ff + 17'd1;
      end else begin
         pos = 16'(MaxLen - 17'd1);
         ovf_in = 1'b1;
      end
      ab = above_ff;
      if (idx_ff == 17'd0) begin
         above_in = gt_on;
      end else begin
         if (gt_on && !ab) begin
            if (on_cnt_ff != 16'hFFFF) on_cnt_in = on_cnt_ff + 16'd1;
            if (!on_seen_ff) begin first_on_in = pos; on_seen_in = 1'b1; end
            ab = 1'b1;
         end
         if (le_off && ab) begin
            if (off_cnt_ff != 16'hFFFF) off_cnt_in = off_cnt_ff + 16'd1;
            last_off_in = pos; off_seen_in = 1'b1;
            ab = 1'b0;
         end
         above_in = ab;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= 1'b0; idx_ff <= '0; on_seen_ff <= 1'b0; off_seen_ff <= 1'b0;
         ovf_ff <= 1'b0; first_on_ff <= '0; last_off_ff <= '0;
         on_cnt_ff <= '0; off_cnt_ff <= '0; end_ff <= 1'b0;
      end else if (cmd.take) begin
         end_ff <= last_sample;
         if (last_sample) begin
            above_ff <= 1'b0; idx_ff <= '0; on_seen_ff <= 1'b0; off_seen_ff <= 1'b0;
            ovf_ff <= 1'b0; first_on_ff <= '0; last_off_ff <= '0;
            on_cnt_ff <= '0; off_cnt_ff <= '0;
         end else begin
            above_ff <= above_in; idx_ff <= idx_in; on_seen_ff <= on_seen_in;
            off_seen_ff <= off_seen_in; ovf_ff <= ovf_in; first_on_ff <= first_on_in;
            last_off_ff <= last_off_in; on_cnt_ff <= on_cnt_in; off_cnt_ff <= off_cnt_in;
         end
      end else begin
         end_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && last_sample) begin
         len_ff <= idx_in;
         son_ff <= on_seen_in ? first_on_in : 16'd0;
         soff_ff <= off_seen_in ? last_off_in : 16'(idx_in - 17'd1);
         son_cnt_ff <= on_cnt_in; soff_cnt_ff <= off_cnt_in; sovf_ff <= ovf_in;
      end
   end

   // products, one multiplier stage each
   logic [19:0] per1;
   logic [35:0] on_us_ff, off_us_ff;
   logic [36:0] lenper_ff;
   logic [43:0] rate_num_ff;
   assign per1 = (per_ff == 20'd0) ? 20'd1 : per_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_mul) begin
         on_us_ff <= son_ff * per1;
         off_us_ff <= soff_ff * per1;
         lenper_ff <= len_ff * per1;
         rate_num_ff <= son_cnt_ff * 28'd256000000;
      end
   end

   logic div_busy;
   logic [63:0] dvd, dvs, quo;
   always_comb begin
      case (cmd.div_sel)
         sood_pkg::SelOn:   begin dvd = {32'd0, son_ff, 16'd0};  dvs = {47'd0, len_ff}; end
         sood_pkg::SelOff:  begin dvd = {32'd0, soff_ff, 16'd0}; dvs = {47'd0, len_ff}; end
         sood_pkg::SelRate: begin dvd = {20'd0, rate_num_ff};     dvs = {27'd0, lenper_ff}; end
         default:           begin dvd = '0; dvs = 64'd1; end
      endcase
   end

   sood_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(dvd),
      .divisor(dvs), .busy(div_busy), .quotient(quo)
   );

   logic [35:0] frac_on_ff, frac_off_ff;
   logic [1:0] sel_q_ff;
   logic was_busy_ff;
   logic [23:0] rate_ff;
   always_ff @(posedge clock) begin
      if (cmd.div_start) sel_q_ff <= cmd.div_sel;
      was_busy_ff <= div_busy;
      if (was_busy_ff && !div_busy) begin
         case (sel_q_ff)
            sood_pkg::SelOn:  frac_on_ff <= quo[35:0];
            sood_pkg::SelOff: frac_off_ff <= quo[35:0];
            default: rate_ff <= (quo > 64'hFF_FFFF) ? 24'hFF_FFFF : quo[23:0];
         endcase
      end
   end

   function automatic logic [35:0] fmt(input logic [1:0] m, input logic [35:0] fr,
                                         input logic [35:0] us, input logic [15:0] p);
      case (m)
         sood_pkg::ModeFrac:  fmt = fr;
         sood_pkg::ModeUs:    fmt = us;
         sood_pkg::ModeFrame: fmt = {20'd0, p};
         default:             fmt = '0;
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         onset_time <= fmt(mode_ff, frac_on_ff, on_us_ff, son_ff);
         offset_time <= fmt(mode_ff, frac_off_ff, off_us_ff, soff_ff);
         onset_count <= son_cnt_ff; offset_count <= soff_cnt_ff;
         onset_rate <= rate_ff; segment_length <= len_ff; overflow <= sovf_ff;
      end
   end

   assign stat.seg_end = end_ff;
   assign stat.div_busy = div_busy | (was_busy_ff & ~div_busy);
   assign stat.frac_mode = (mode_ff == sood_pkg::ModeFrac);
   logic unused;
   assign unused = ^Mask36;
endmodule
`default_nettype wire

FILE: src/sood_ctrl.sv
// Controller state machine: sample intake and end-of-segment sequencing.
// Depends on sood_pkg.
`default_nettype none
module sood_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   input  wire sood_pkg::stat_type stat,
   output sood_pkg::cmd_type cmd
);
   sood_pkg::state_type st_ff, st_in;
   logic rv_ff, rv_in;
   // rate divide launch after MUL in non-fraction modes
   logic rate_go_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         sood_pkg::ST_IDLE:     if (stat.seg_end) st_in = sood_pkg::ST_MUL;
         sood_pkg::ST_MUL:      st_in = stat.frac_mode ? sood_pkg::ST_DIV_ON
                                                       : sood_pkg::ST_DIV_RATE;
         sood_pkg::ST_DIV_ON:   if (!stat.div_busy) st_in = sood_pkg::ST_DIV_OFF;
         sood_pkg::ST_DIV_OFF:  if (!stat.div_busy) st_in = sood_pkg::ST_DIV_RATE;
         sood_pkg::ST_DIV_RATE: if (!stat.div_busy && !rate_go_ff) st_in = sood_pkg::ST_OUT;
         sood_pkg::ST_OUT:      if (!rv_ff || rsp_ready) st_in = sood_pkg::ST_IDLE;
         default:               st_in = sood_pkg::ST_IDLE;
      endcase
   end

   logic entering;
   always_comb begin
      cmd = '0;
      entering = 1'b0;
      req_ready = (st_ff == sood_pkg::ST_IDLE) && !stat.seg_end;
      cmd.take = req_ready && req_valid;
      case (st_ff)
         sood_pkg::ST_MUL: begin
            cmd.start_mul = 1'b1;
            // onset fraction divide only needs the snapshot
            entering = stat.frac_mode;
            cmd.div_sel = sood_pkg::SelOn;
         end
         sood_pkg::ST_DIV_ON: begin
            cmd.div_sel = sood_pkg::SelOff;
            entering = !stat.div_busy;
         end
         sood_pkg::ST_DIV_OFF: begin
            cmd.div_sel = sood_pkg::SelRate;
            entering = !stat.div_busy;
         end
         sood_pkg::ST_DIV_RATE: begin
            // rate divide needs the products, so it starts the cycle after ST_MUL
            cmd.div_sel = sood_pkg::SelRate;
            entering = rate_go_ff;
         end
         sood_pkg::ST_OUT: cmd.load_out = !rv_ff || rsp_ready;
         default: ;
      endcase
      cmd.div_start = entering;
   end

   always_ff @(posedge clock) begin
      if (reset) rate_go_ff <= 1'b0;
      else rate_go_ff <= (st_ff == sood_pkg::ST_MUL) && !stat.frac_mode;
   end

   sood_pkg::cmd_type cmd_i;
   always_comb begin
      cmd_i = cmd;
   end

   always_comb begin
      rv_in = rv_ff;
      if (rsp_ready) rv_in = 1'b0;
      if (cmd.load_out) rv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= sood_pkg::ST_IDLE; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   logic unused;
   assign unused = cmd_i.take;
endmodule
`default_nettype wire

FILE: src/segment_onset_offset_detector_core.sv
// Segment onset/offset detector, top level. Depends on sood_pkg, sood_if,
// sood_ctrl, sood_datapath.
//
// Takes one sample request per cycle while a segment streams in; hysteresis
// compare and counting finish in the accept cycle. The request flagged
// last_sample ends the segment: intake then pauses while one radix-2
// divider is reused for the fraction positions (two divides, only in
// fraction mode) and the onset rate (one divide), and the result is then
// loaded into the response register. The response register holds until
// taken; the next segment's samples are accepted once the result is loaded.
// Configuration writes take effect at once and belong between segments.
`default_nettype none
module segment_onset_offset_detector_core (
   input  wire logic clock,
   input  wire logic reset,
   sood_req_if.sink req,
   sood_rsp_if.source rsp,
   input  wire logic csr_write_enable,
   input  wire logic [2:0] csr_index,
   input  wire logic [19:0] csr_write_data
);
   sood_pkg::cmd_type cmd;
   sood_pkg::stat_type stat;

   sood_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .stat(stat), .cmd(cmd)
   );

   sood_datapath u_dp (
      .clock(clock), .reset(reset), .csr_write_enable(csr_write_enable),
      .csr_index(csr_index), .csr_write_data(csr_write_data),
      .sample(req.sample), .last_sample(req.last_sample), .cmd(cmd), .stat(stat),
      .onset_time(rsp.onset_time), .offset_time(rsp.offset_time),
      .onset_count(rsp.onset_count), .offset_count(rsp.offset_count),
      .onset_rate(rsp.onset_rate), .segment_length(rsp.segment_length),
      .overflow(rsp.overflow)
   );
endmodule
`default_nettype wire
